/* rtl/rrct_pkg.sv */
package rrct_pkg;

  localparam int WORD_W = 32;
  localparam int SLOT_IDX_W = 4;

  // command codes
  localparam logic CMD_SCHED = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  // slot status codes
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [WORD_W-1:0] stack_ptr;
    logic [WORD_W-1:0] sys_stack;
    logic [WORD_W-1:0] page_dir;
  } rrct_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]     out_stack_ptr;
    logic [WORD_W-1:0]     out_sys_stack;
    logic [WORD_W-1:0]     out_page_dir;
    logic                  load_page_dir;
    logic                  switched;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  accepted;
  } rrct_out_t;

  // write strobes into the context memories
  typedef struct packed {
    logic sp_we;
    logic ctx_we;
  } rrct_mem_ctl_t;

endpackage

/* rtl/round_robin_context_table_unit.sv */
// add: scans from slot 0 for the lowest empty slot; the add is dropped when the table is full
// schedule: scans from the slot after the running one, skipping empty slots; no task echoes sp
// one word at a time: the next word is taken only once the result for the last has issued
// a new word is taken once the sequencer is back in idle, even while a result waits on stall
// reset: synchronous active-low rst_n empties all slots, clears task count and running state
// context memories have no reset and are only read for slots that were filled
module round_robin_context_table_unit import rrct_pkg::*; #(
  parameter int SLOT_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rrct_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rrct_out_t out_data
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] LAST_TRY = CW'(SLOT_COUNT - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_SCHED = 3'd2;
  localparam logic [2:0] S_SKIP  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state_r;
  rrct_in_t      in_r;
  logic [IW-1:0] idx_r;          // shared scan pointer
  logic [CW-1:0] tries_r;        // slots visited by the skip scan
  logic [CW-1:0] count_r;        // high-water task count
  logic          run_valid_r;
  logic [IW-1:0] run_slot_r;
  rrct_out_t     res_r;          // result being assembled
  rrct_out_t     res_nxt;
  logic          fin_add_r;      // commit an add in the final step
  logic          fin_sched_r;    // commit a switch in the final step
  logic          out_valid_r;
  rrct_out_t     out_r;
  logic [1:0]    status_r [SLOT_COUNT];

  logic          in_acc;
  logic          out_free;
  logic [1:0]    cur_status;
  logic [IW-1:0] next_idx;
  logic [IW-1:0] rr_start;

  rrct_mem_ctl_t     mem_ctl;
  logic [IW-1:0]     mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_sp;
  logic              mem_rd_en;
  logic [WORD_W-1:0] rd_sp;
  logic [WORD_W-1:0] rd_ks;
  logic [WORD_W-1:0] rd_pd;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur_status = status_r[idx_r];
  assign next_idx   = (idx_r == LAST_IDX) ? '0 : idx_r + IW'(1);

  // round-robin start: next slot after the running one, wrapped at the task count
  assign rr_start = !run_valid_r ? '0 :
                    ((CW'(run_slot_r) + CW'(1)) == count_r) ? '0 : run_slot_r + IW'(1);

  // memory port control
  always_comb begin
    mem_ctl     = '0;
    mem_wr_addr = idx_r;
    mem_wr_sp   = in_r.stack_ptr;
    mem_rd_en   = 1'b0;
    unique case (state_r)
      S_SCHED: begin
        // save the outgoing stack pointer
        mem_ctl.sp_we = (count_r != '0) && run_valid_r;
        mem_wr_addr   = run_slot_r;
      end
      S_SKIP: begin
        mem_rd_en = (cur_status != ST_EMPTY);
      end
      S_FIN: begin
        mem_ctl.sp_we  = fin_add_r && out_free;
        mem_ctl.ctx_we = fin_add_r && out_free;
      end
      default: begin
      end
    endcase
  end

  rrct_ctx_mem #(
    .SLOT_COUNT(SLOT_COUNT),
    .IW        (IW)
  ) u_mem (
    .clk    (clk),
    .wr_ctl (mem_ctl),
    .wr_addr(mem_wr_addr),
    .wr_sp  (mem_wr_sp),
    .wr_ks  (in_r.sys_stack),
    .wr_pd  (in_r.page_dir),
    .rd_en  (mem_rd_en),
    .rd_addr(idx_r),
    .rd_sp  (rd_sp),
    .rd_ks  (rd_ks),
    .rd_pd  (rd_pd)
  );

  // next result payload per sequencer step
  always_comb begin
    res_nxt = res_r;
    unique case (state_r)
      S_ADD: begin
        res_nxt = '0;
        if (cur_status == ST_EMPTY) begin
          res_nxt.slot_index = SLOT_IDX_W'(idx_r);
          res_nxt.accepted   = 1'b1;
        end
      end
      S_SCHED: begin
        // no task: echo the stack pointer, rest zero
        res_nxt               = '0;
        res_nxt.out_stack_ptr = in_r.stack_ptr;
      end
      S_READ: begin
        res_nxt.out_stack_ptr = rd_sp;
        res_nxt.out_sys_stack = rd_ks;
        res_nxt.out_page_dir  = rd_pd;
        res_nxt.load_page_dir = (rd_pd != '0);
        res_nxt.switched      = 1'b1;
        res_nxt.slot_index    = SLOT_IDX_W'(idx_r);
        res_nxt.accepted      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // input capture and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (state_r == S_FIN && out_free) begin
      out_r <= res_r;
    end
    res_r <= res_nxt;
  end

  // sequencer and table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      tries_r     <= '0;
      count_r     <= '0;
      run_valid_r <= 1'b0;
      run_slot_r  <= '0;
      fin_add_r   <= 1'b0;
      fin_sched_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status_r[i] <= ST_EMPTY;
      end
    end else begin
      // the final step reloads the result register itself
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          idx_r   <= '0;
          tries_r <= '0;
          if (in_acc) begin
            state_r <= (in_data.cmd == CMD_ADD) ? S_ADD : S_SCHED;
          end
        end
        S_ADD: begin
          // look for the lowest empty slot
          if (cur_status == ST_EMPTY) begin
            fin_add_r   <= 1'b1;
            fin_sched_r <= 1'b0;
            state_r     <= S_FIN;
          end else if (idx_r == LAST_IDX) begin
            // table full, drop the add
            fin_add_r   <= 1'b0;
            fin_sched_r <= 1'b0;
            state_r     <= S_FIN;
          end else begin
            idx_r <= next_idx;
          end
        end
        S_SCHED: begin
          fin_add_r   <= 1'b0;
          fin_sched_r <= 1'b0;
          if (count_r == '0) begin
            state_r <= S_FIN;
          end else begin
            if (run_valid_r) begin
              status_r[run_slot_r] <= ST_READY;
            end
            idx_r   <= rr_start;
            tries_r <= '0;
            state_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          // skip empty slots, wrapping at the table size
          if (cur_status != ST_EMPTY) begin
            state_r <= S_READ;
          end else if (tries_r == LAST_TRY) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= next_idx;
            tries_r <= tries_r + CW'(1);
          end
        end
        S_READ: begin
          fin_sched_r <= 1'b1;
          state_r     <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (fin_add_r) begin
              status_r[idx_r] <= ST_READY;
              if (CW'(idx_r) >= count_r) begin
                count_r <= CW'(idx_r) + CW'(1);
              end
            end
            if (fin_sched_r) begin
              status_r[idx_r] <= ST_RUNNING;
              run_slot_r      <= idx_r;
              run_valid_r     <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/rrct_ctx_mem.sv */
module rrct_ctx_mem import rrct_pkg::*; #(
  parameter int SLOT_COUNT = 16,
  parameter int IW = 4
) (
  input  logic              clk,
  input  rrct_mem_ctl_t     wr_ctl,
  input  logic [IW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_sp,
  input  logic [WORD_W-1:0] wr_ks,
  input  logic [WORD_W-1:0] wr_pd,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_sp,
  output logic [WORD_W-1:0] rd_ks,
  output logic [WORD_W-1:0] rd_pd
);

  logic [WORD_W-1:0] sp_mem [SLOT_COUNT];
  logic [WORD_W-1:0] ks_mem [SLOT_COUNT];
  logic [WORD_W-1:0] pd_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_ctl.sp_we) begin
      sp_mem[wr_addr] <= wr_sp;
    end
    if (wr_ctl.ctx_we) begin
      ks_mem[wr_addr] <= wr_ks;
      pd_mem[wr_addr] <= wr_pd;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sp <= sp_mem[rd_addr];
      rd_ks <= ks_mem[rd_addr];
      rd_pd <= pd_mem[rd_addr];
    end
  end

endmodule

/* rtl/rrct_checker.sv */
module rrct_checker import rrct_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input rrct_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // one word in flight: the cycle after an accept the input is stalled
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  // a stored add never reports a switch
  a_add_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.switched)
    else $error("add result flagged as switch");

  // without a switch no context is returned
  a_no_switch_no_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.switched |->
      !out_data.load_page_dir && out_data.out_page_dir == '0 &&
      out_data.out_sys_stack == '0)
    else $error("context returned without a switch");

endmodule

bind round_robin_context_table_unit rrct_checker u_rrct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
